FILE: rtl/trs_pkg.sv
// shared types and constants for the trs matrix build pipeline
package trs_pkg;

    // input beat: one keyframe
    typedef struct packed {
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } trs_in_t;

    // output beat: affine matrix without the constant bottom row
    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] tx_out;
        logic signed [31:0] ty_out;
        logic signed [31:0] tz_out;
    } trs_out_t;

    // number of 3x3 entries, indexed row * 3 + column
    localparam int NUM_ENT  = 9;
    localparam int NUM_AXIS = 3;

    // q16.16 word, q.29 rotation entry, q.45 scaled entry
    typedef logic signed [31:0] trs_word_t;
    typedef logic signed [32:0] trs_rot_t;
    typedef logic signed [63:0] trs_wide_t;

    // 1.0 at q.29
    localparam trs_rot_t ROT_ONE = 33'sd536870912;
    // half an output lsb at q.45
    localparam trs_wide_t RND_HALF = 64'sd268435456;
    localparam trs_word_t SAT_MAX = 32'sh7fffffff;
    localparam trs_word_t SAT_MIN = 32'sh80000000;

    // beat after the rotation stage
    typedef struct packed {
        trs_word_t [NUM_AXIS-1:0] trans;
        trs_word_t [NUM_AXIS-1:0] scale;
        trs_rot_t  [NUM_ENT-1:0]  rot;
    } trs_rot_beat_t;

    // beat after the scale multiply stage
    typedef struct packed {
        trs_word_t [NUM_AXIS-1:0] trans;
        trs_wide_t [NUM_ENT-1:0]  prod;
    } trs_prod_beat_t;

endpackage

FILE: rtl/trs_quat_rot.sv
// quaternion products and rotation entries, two register stages
module trs_quat_rot (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  trs_pkg::trs_in_t       in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output trs_pkg::trs_rot_beat_t out_data
);
    import trs_pkg::*;

    // product slots
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int P_WX = 6;
    localparam int P_WY = 7;
    localparam int P_WZ = 8;

    typedef struct packed {
        trs_word_t [NUM_AXIS-1:0] trans;
        trs_word_t [NUM_AXIS-1:0] scale;
        trs_word_t [NUM_ENT-1:0]  qp;
    } qprod_beat_t;

    function automatic trs_rot_t ext33(trs_word_t a);
        return {a[31], a};
    endfunction

    logic          qp_valid_reg;
    qprod_beat_t   qp_reg;
    qprod_beat_t   qp_next;
    logic          rot_valid_reg;
    trs_rot_beat_t rot_reg;
    trs_rot_beat_t rot_next;
    logic          qp_en;
    logic          rot_en;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;

    // per-stage advance, bubbles collapse
    assign rot_en   = !rot_valid_reg || out_ready;
    assign qp_en    = !qp_valid_reg || rot_en;
    assign in_ready = qp_en;

    // quaternion component products, exact q2.30
    always_comb begin
        qw = $signed(in_data.quat_w);
        qx = $signed(in_data.quat_x);
        qy = $signed(in_data.quat_y);
        qz = $signed(in_data.quat_z);
        qp_next.trans = {in_data.trans_z, in_data.trans_y, in_data.trans_x};
        qp_next.scale = {in_data.scale_z, in_data.scale_y, in_data.scale_x};
        qp_next.qp[P_XX] = qx * qx;
        qp_next.qp[P_YY] = qy * qy;
        qp_next.qp[P_ZZ] = qz * qz;
        qp_next.qp[P_XY] = qx * qy;
        qp_next.qp[P_XZ] = qx * qz;
        qp_next.qp[P_YZ] = qy * qz;
        qp_next.qp[P_WX] = qw * qx;
        qp_next.qp[P_WY] = qw * qy;
        qp_next.qp[P_WZ] = qw * qz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qp_valid_reg <= 1'b0;
        end else if (qp_en) begin
            qp_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (qp_en && in_valid) begin
            qp_reg <= qp_next;
        end
    end

    // rotation entries at q.29 (half of the q.30 value)
    always_comb begin
        rot_next.trans = qp_reg.trans;
        rot_next.scale = qp_reg.scale;
        rot_next.rot[0] = ROT_ONE - (ext33(qp_reg.qp[P_YY]) + ext33(qp_reg.qp[P_ZZ]));
        rot_next.rot[1] = ext33(qp_reg.qp[P_XY]) - ext33(qp_reg.qp[P_WZ]);
        rot_next.rot[2] = ext33(qp_reg.qp[P_XZ]) + ext33(qp_reg.qp[P_WY]);
        rot_next.rot[3] = ext33(qp_reg.qp[P_XY]) + ext33(qp_reg.qp[P_WZ]);
        rot_next.rot[4] = ROT_ONE - (ext33(qp_reg.qp[P_XX]) + ext33(qp_reg.qp[P_ZZ]));
        rot_next.rot[5] = ext33(qp_reg.qp[P_YZ]) - ext33(qp_reg.qp[P_WX]);
        rot_next.rot[6] = ext33(qp_reg.qp[P_XZ]) - ext33(qp_reg.qp[P_WY]);
        rot_next.rot[7] = ext33(qp_reg.qp[P_YZ]) + ext33(qp_reg.qp[P_WX]);
        rot_next.rot[8] = ROT_ONE - (ext33(qp_reg.qp[P_XX]) + ext33(qp_reg.qp[P_YY]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_valid_reg <= 1'b0;
        end else if (rot_en) begin
            rot_valid_reg <= qp_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rot_en && qp_valid_reg) begin
            rot_reg <= rot_next;
        end
    end

    assign out_valid = rot_valid_reg;
    assign out_data  = rot_reg;

    // diagonal entries never exceed one
    a_diag_le_one: assert property (@(posedge aclk) disable iff (!aresetn)
        rot_valid_reg |-> ($signed(rot_reg.rot[0]) <= ROT_ONE
                        && $signed(rot_reg.rot[4]) <= ROT_ONE
                        && $signed(rot_reg.rot[8]) <= ROT_ONE))
        else $error("diagonal rotation entry above one");

endmodule

FILE: rtl/trs_scale_mul.sv
// rotation entry times column scale, one register stage
module trs_scale_mul (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  trs_pkg::trs_rot_beat_t  in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output trs_pkg::trs_prod_beat_t out_data
);
    import trs_pkg::*;

    logic           prod_valid_reg;
    trs_prod_beat_t prod_reg;
    trs_prod_beat_t prod_next;
    logic           prod_en;
    logic signed [64:0] full [NUM_ENT];

    assign prod_en  = !prod_valid_reg || out_ready;
    assign in_ready = prod_en;

    // one 33x32 multiplier per entry, column picks the scale
    for (genvar k = 0; k < NUM_ENT; k++) begin : g_mul
        localparam int COL = k % NUM_AXIS;
        assign full[k] = $signed(in_data.rot[k]) * $signed(in_data.scale[COL]);
        assign prod_next.prod[k] = full[k][63:0];
    end
    assign prod_next.trans = in_data.trans;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_en) begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_en && in_valid) begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = prod_valid_reg;
    assign out_data  = prod_reg;

    // a zero x scale clears its whole column
    a_zero_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (prod_en && in_valid && in_data.scale[0] == '0)
        |=> (prod_reg.prod[0] == '0 && prod_reg.prod[3] == '0 && prod_reg.prod[6] == '0))
        else $error("zero x scale gave a nonzero column");

endmodule

FILE: rtl/trs_round_sat.sv
// rounding to q16.16, saturation and the output register
module trs_round_sat (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  trs_pkg::trs_prod_beat_t in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output trs_pkg::trs_out_t       out_data
);
    import trs_pkg::*;

    // round half up then clamp to the 32-bit range
    function automatic trs_word_t round_sat(trs_wide_t p);
        trs_wide_t   v;
        logic [34:0] q;
        v = p + RND_HALF;
        q = v[63:29];
        if (q[34:31] == 4'b0000 || q[34:31] == 4'b1111) begin
            return q[31:0];
        end else if (q[34]) begin
            return SAT_MIN;
        end else begin
            return SAT_MAX;
        end
    endfunction

    logic     out_valid_reg;
    trs_out_t out_reg;
    trs_out_t out_next;
    logic     out_en;

    assign out_en   = !out_valid_reg || out_ready;
    assign in_ready = out_en;

    // assemble the result beat
    always_comb begin
        out_next.m00    = round_sat(in_data.prod[0]);
        out_next.m01    = round_sat(in_data.prod[1]);
        out_next.m02    = round_sat(in_data.prod[2]);
        out_next.m10    = round_sat(in_data.prod[3]);
        out_next.m11    = round_sat(in_data.prod[4]);
        out_next.m12    = round_sat(in_data.prod[5]);
        out_next.m20    = round_sat(in_data.prod[6]);
        out_next.m21    = round_sat(in_data.prod[7]);
        out_next.m22    = round_sat(in_data.prod[8]);
        out_next.tx_out = in_data.trans[0];
        out_next.ty_out = in_data.trans[1];
        out_next.tz_out = in_data.trans[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_en) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && in_valid) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/trs_matrix_build.sv
// top level of the trs to affine bone matrix pipeline
//
// s_ channel takes one keyframe beat: translation and scale in q16.16,
// quaternion in q1.15 (used as given, not normalized). m_ channel returns
// one beat per keyframe: the 3x3 part of translate * rotate * scale in
// q16.16, rounded half up and saturated, plus the translation column
// passed through unchanged. The bottom row 0,0,0,1 is not sent.
//
// From s_ accept to m_valid: quaternion products, rotation entries, the
// nine 33x32 scale multipliers, then rounding into the output register.
// Throughput is one beat per cycle while m_ready is high; each stage has
// its own valid bit and loads when it is empty or its successor moves.
//
// Reset (aresetn low, synchronous) clears all stage valid bits; beats in
// flight are dropped and none is created. When the receiver holds m_ready
// low, the output holds, earlier stages keep filling bubbles, and s_ready
// drops only once all four stages hold a beat.
module trs_matrix_build (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  trs_pkg::trs_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output trs_pkg::trs_out_t m_data
);
    import trs_pkg::*;

    logic           rot_valid;
    logic           rot_ready;
    trs_rot_beat_t  rot_data;
    logic           prod_valid;
    logic           prod_ready;
    trs_prod_beat_t prod_data;

    // products and rotation entries
    trs_quat_rot u_quat_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    // scale multiply
    trs_scale_mul u_scale_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    // round, saturate, output register
    trs_round_sat u_round_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // input backpressure only with a full pipeline
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && prod_valid && rot_valid))
        else $error("s_ready low with an empty stage");

    // a stalled output never drops its beat
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("output beat changed while stalled");

endmodule

FILE: sim/testbench.sv
// testbench for trs_matrix_build: keyframe to affine bone matrix pipeline
`timescale 1ns / 1ps

module testbench;
    import trs_pkg::*;

    localparam int OUT_BITS  = $bits(trs_out_t);
    localparam int OUT_WORDS = 12;
    localparam int IDLE_PCT  = 36;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    trs_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    trs_out_t m_data;

    // predicted matrices, oldest first
    trs_out_t expected_matrices[$];
    int keyframes_accepted = 0;
    int matrices_checked = 0;
    int failure_count = 0;
    int sink_hold_left = 0;
    bit src_idle_en = 1'b1;
    bit sink_idle_en = 1'b1;

    string field_names[OUT_WORDS] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                      "m20", "m21", "m22", "tx_out", "ty_out", "tz_out"};

    trs_matrix_build i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // q.29 rotation entry times q16.16 scale, round half up, saturate to 32 bits
    function automatic trs_word_t scale_round_sat(input longint rot29, input longint scl);
        longint prod;
        longint quot;
        prod = rot29 * scl + (longint'(1) <<< 28);
        quot = prod >>> 29;
        if (quot > longint'(32'sh7fffffff))
            quot = 64'sd2147483647;
        if (quot < -64'sd2147483648)
            quot = -64'sd2147483648;
        return trs_word_t'(quot);
    endfunction

    // affine matrix T * R(q) * S for one keyframe
    function automatic trs_out_t build_bone_matrix(input trs_in_t kf);
        longint qw, qx, qy, qz, sx, sy, sz;
        longint half_one;
        longint rot[9];
        trs_out_t mtx;
        qw = kf.quat_w;
        qx = kf.quat_x;
        qy = kf.quat_y;
        qz = kf.quat_z;
        sx = kf.scale_x;
        sy = kf.scale_y;
        sz = kf.scale_z;
        half_one = longint'(1) <<< 29;
        // rotation entries at q.29, index row * 3 + column
        rot[0] = half_one - (qy * qy + qz * qz);
        rot[1] = qx * qy - qw * qz;
        rot[2] = qx * qz + qw * qy;
        rot[3] = qx * qy + qw * qz;
        rot[4] = half_one - (qx * qx + qz * qz);
        rot[5] = qy * qz - qw * qx;
        rot[6] = qx * qz - qw * qy;
        rot[7] = qy * qz + qw * qx;
        rot[8] = half_one - (qx * qx + qy * qy);
        // column j carries scale component j
        mtx.m00 = scale_round_sat(rot[0], sx);
        mtx.m01 = scale_round_sat(rot[1], sy);
        mtx.m02 = scale_round_sat(rot[2], sz);
        mtx.m10 = scale_round_sat(rot[3], sx);
        mtx.m11 = scale_round_sat(rot[4], sy);
        mtx.m12 = scale_round_sat(rot[5], sz);
        mtx.m20 = scale_round_sat(rot[6], sx);
        mtx.m21 = scale_round_sat(rot[7], sy);
        mtx.m22 = scale_round_sat(rot[8], sz);
        mtx.tx_out = kf.trans_x;
        mtx.ty_out = kf.trans_y;
        mtx.tz_out = kf.trans_z;
        return mtx;
    endfunction

    // receiver: random idling, or a long counted hold-off when requested
    always @(negedge aclk) begin
        if (sink_hold_left > 0) begin
            m_ready <= 1'b0;
            sink_hold_left <= sink_hold_left - 1;
        end else if (sink_idle_en) begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // predict on each accepted keyframe, compare each accepted matrix beat
    always @(posedge aclk) begin : matrix_compare
        logic [OUT_BITS-1:0] want_bits;
        logic [OUT_BITS-1:0] got_bits;
        bit bad;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_matrices.push_back(build_bone_matrix(s_data));
                keyframes_accepted++;
            end
            if (m_valid && m_ready) begin
                if (expected_matrices.size() == 0) begin
                    failure_count++;
                    if (failure_count <= 10)
                        $display("[%0t] unexpected matrix beat %h", $time, m_data);
                end else begin
                    want_bits = expected_matrices.pop_front();
                    got_bits = m_data;
                    bad = 1'b0;
                    for (int k = 0; k < OUT_WORDS; k++) begin
                        if (want_bits[OUT_BITS-1-32*k -: 32] !== got_bits[OUT_BITS-1-32*k -: 32])
                            bad = 1'b1;
                    end
                    if (bad) begin
                        failure_count++;
                        if (failure_count <= 10) begin
                            for (int k = 0; k < OUT_WORDS; k++) begin
                                if (want_bits[OUT_BITS-1-32*k -: 32]
                                        !== got_bits[OUT_BITS-1-32*k -: 32])
                                    $display("[%0t] matrix %0d %s: expected %h, got %h",
                                             $time, matrices_checked, field_names[k],
                                             want_bits[OUT_BITS-1-32*k -: 32],
                                             got_bits[OUT_BITS-1-32*k -: 32]);
                            end
                        end
                    end
                    matrices_checked++;
                end
            end
        end
    end

    // offer one keyframe beat; called and returns at a falling edge
    task automatic send_keyframe(input trs_in_t kf);
        while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= kf;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // stop offering and wait until every predicted matrix has come out or max_cycles runs out
    task automatic wait_all_results(input int max_cycles);
        s_valid <= 1'b0;
        do begin
            @(negedge aclk);
            max_cycles--;
        end while (expected_matrices.size() != 0 && max_cycles > 0);
    endtask

    function automatic trs_in_t make_keyframe(input int tx, input int ty, input int tz,
                                              input shortint qw, input shortint qx,
                                              input shortint qy, input shortint qz,
                                              input int sx, input int sy, input int sz);
        trs_in_t kf;
        kf.trans_x = tx;
        kf.trans_y = ty;
        kf.trans_z = tz;
        kf.quat_w = qw;
        kf.quat_x = qx;
        kf.quat_y = qy;
        kf.quat_z = qz;
        kf.scale_x = sx;
        kf.scale_y = sy;
        kf.scale_z = sz;
        return kf;
    endfunction

    function automatic logic [31:0] pick_word32();
        case ($urandom_range(7))
            0: return 32'h00000000;
            1: return 32'h00000001;
            2: return 32'hffffffff;
            3: return 32'h7fffffff;
            4: return 32'h80000000;
            5: return 32'h00010000;
            6: return 32'hffff0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_word16();
        case ($urandom_range(6))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hffff;
            3: return 16'h7fff;
            4: return 16'h8000;
            5: return 16'h5a82;
            default: return 16'($urandom);
        endcase
    endfunction

    // half well-formed keyframes, some raw bits, some corner words
    function automatic trs_in_t random_keyframe();
        trs_in_t kf;
        real qa, qb, qc, qd, qn;
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            // unit quaternion, translation within +-16384, scale within +-4.0
            qa = real'(int'($urandom_range(20000)) - 10000);
            qb = real'(int'($urandom_range(20000)) - 10000);
            qc = real'(int'($urandom_range(20000)) - 10000);
            qd = real'(int'($urandom_range(20000)) - 10000);
            qn = $sqrt(qa * qa + qb * qb + qc * qc + qd * qd);
            if (qn < 1.0) begin
                qa = 1.0;
                qn = 1.0;
            end
            kf.quat_w = 16'($rtoi(qa / qn * 32767.0));
            kf.quat_x = 16'($rtoi(qb / qn * 32767.0));
            kf.quat_y = 16'($rtoi(qc / qn * 32767.0));
            kf.quat_z = 16'($rtoi(qd / qn * 32767.0));
            kf.trans_x = $signed($urandom) >>> 1;
            kf.trans_y = $signed($urandom) >>> 1;
            kf.trans_z = $signed($urandom) >>> 1;
            kf.scale_x = int'($urandom_range(32'h80000)) - 32'sh40000;
            if ($urandom_range(3) == 0) begin
                kf.scale_y = kf.scale_x;
                kf.scale_z = kf.scale_x;
            end else begin
                kf.scale_y = int'($urandom_range(32'h80000)) - 32'sh40000;
                kf.scale_z = int'($urandom_range(32'h80000)) - 32'sh40000;
            end
        end else if (pick < 80) begin
            kf.trans_x = $urandom;
            kf.trans_y = $urandom;
            kf.trans_z = $urandom;
            kf.quat_w = 16'($urandom);
            kf.quat_x = 16'($urandom);
            kf.quat_y = 16'($urandom);
            kf.quat_z = 16'($urandom);
            kf.scale_x = $urandom;
            kf.scale_y = $urandom;
            kf.scale_z = $urandom;
        end else begin
            kf.trans_x = pick_word32();
            kf.trans_y = pick_word32();
            kf.trans_z = pick_word32();
            kf.quat_w = pick_word16();
            kf.quat_x = pick_word16();
            kf.quat_y = pick_word16();
            kf.quat_z = pick_word16();
            kf.scale_x = pick_word32();
            kf.scale_y = pick_word32();
            kf.scale_z = pick_word32();
        end
        return kf;
    endfunction

    // field extremes, identity, axis flips, saturation, rounding ties
    task automatic test_directed_corners();
        localparam int ONE = 32'sh00010000;
        localparam int SMAX = 32'sh7fffffff;
        localparam int SMIN = 32'sh80000000;
        trs_in_t kf_list[$];
        kf_list.push_back(make_keyframe(0, 0, 0, 32767, 0, 0, 0, ONE, ONE, ONE));
        kf_list.push_back(make_keyframe(SMAX, SMIN, -1, 32767, 0, 0, 0, ONE, ONE, ONE));
        kf_list.push_back(make_keyframe(SMIN, SMAX, 1, 0, 0, 0, 0, ONE, ONE, ONE));
        kf_list.push_back(make_keyframe(1, 2, 3, 0, 0, 0, 0, SMAX, SMAX, SMAX));
        kf_list.push_back(make_keyframe(-1, -2, -3, 0, 0, 0, 0, SMIN, SMIN, SMIN));
        kf_list.push_back(make_keyframe(0, 0, 0, -32768, 0, 0, 0, ONE, ONE, ONE));
        kf_list.push_back(make_keyframe(0, 0, 0, 0, -32768, 0, 0, ONE, ONE, ONE));
        kf_list.push_back(make_keyframe(0, 0, 0, 0, 0, -32768, 0, ONE, ONE, ONE));
        kf_list.push_back(make_keyframe(0, 0, 0, 0, 0, 0, -32768, ONE, ONE, ONE));
        // off-diagonal products reach 2^31 and saturate both ways
        kf_list.push_back(make_keyframe(SMAX, SMAX, SMAX, -32768, -32768, -32768, -32768,
                                        SMAX, SMAX, SMAX));
        kf_list.push_back(make_keyframe(SMIN, SMIN, SMIN, -32768, -32768, -32768, -32768,
                                        SMIN, SMIN, SMIN));
        kf_list.push_back(make_keyframe(0, 0, 0, 32767, 32767, 32767, 32767,
                                        SMAX, SMIN, SMAX));
        kf_list.push_back(make_keyframe(5, 6, 7, 32767, -32768, 32767, -32768,
                                        SMIN, SMAX, -ONE));
        // quarter turn about z with uneven scale
        kf_list.push_back(make_keyframe(ONE, -ONE, 3 * ONE, 23170, 0, 0, 23170,
                                        2 * ONE, ONE / 2, -3 * ONE));
        // exact rounding ties: +half rounds up, -half rounds to zero
        kf_list.push_back(make_keyframe(0, 0, 0, 0, 1, 1, 0,
                                        32'sh10000000, 32'shf0000000, 32'sh10000000));
        kf_list.push_back(make_keyframe(0, 0, 0, 0, 1, 1, 1,
                                        32'sh0fffffff, 32'shf0000001, -32'sh10000000));
        // non-unit quaternion used as given
        kf_list.push_back(make_keyframe(0, 0, 0, 16384, 16384, 0, 0, ONE, ONE, ONE));
        kf_list.push_back(make_keyframe(0, 0, 0, 1000, -2000, 3000, -4000, ONE, ONE, ONE));
        // zero scale
        kf_list.push_back(make_keyframe(123, 456, 789, 32767, 32767, 0, 0, 0, 0, 0));
        kf_list.push_back(make_keyframe(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f,
                                        16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0,
                                        32'h55555555, 32'haaaaaaaa, 32'hf0f0f0f0));
        foreach (kf_list[i])
            send_keyframe(kf_list[i]);
        wait_all_results(1000);
    endtask

    // random stream with idling on both sides, pausing to drain now and then
    task automatic test_random_stream(input int n_items);
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            send_keyframe(random_keyframe());
            if (i % 150 == 149)
                wait_all_results(2000);
        end
        wait_all_results(2000);
    endtask

    // receiver holds off while the sender keeps offering; the pipeline fills up
    task automatic test_output_backpressure(input int n_items);
        src_idle_en = 1'b0;
        s_valid <= 1'b0;
        @(posedge aclk);
        sink_hold_left = 300;
        @(negedge aclk);
        for (int i = 0; i < n_items; i++)
            send_keyframe(random_keyframe());
        wait_all_results(2000);
        src_idle_en = 1'b1;
    endtask

    // back-to-back beats with no idling on either side
    task automatic test_burst_no_idle(input int n_items);
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        for (int i = 0; i < n_items; i++)
            send_keyframe(random_keyframe());
        wait_all_results(2000);
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_corners();
        test_random_stream(600);
        test_output_backpressure(40);
        test_burst_no_idle(200);
        // pipeline is 4 deep; keep watching for stray beats after the drain
        repeat (12) @(negedge aclk);
        if (expected_matrices.size() != 0) begin
            failure_count += expected_matrices.size();
            $display("%0d predicted matrices never came out", expected_matrices.size());
        end
        $display("run covered %0d keyframes: corners, saturation, rounding ties, random,",
                 keyframes_accepted);
        $display("output hold-off and idle-free bursts; %0d matrices checked, %0d failures",
                 matrices_checked, failure_count);
        if (failure_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(64'd2_000_000);
        $display("timeout with %0d matrices outstanding", expected_matrices.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/trs_pkg.sv
rtl/trs_quat_rot.sv
rtl/trs_scale_mul.sv
rtl/trs_round_sat.sv
rtl/trs_matrix_build.sv
sim/testbench.sv
